// File: rtl/core/tlcg_pkg.sv
// Shared types, constants and the palette table of the timed LED color gradient core.
// Used by every module of the core; depends on nothing.
package tlcg_pkg;

  localparam int PROGRESS_FRAC_BITS = 10;
  localparam int TIME_BITS          = 32;

  localparam int DUR_W   = 32;
  localparam int DEB_W   = 16;
  localparam int CFG_W   = 32;
  localparam int P_W     = PROGRESS_FRAC_BITS + 1;
  localparam int NUM_W   = TIME_BITS + PROGRESS_FRAC_BITS;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int P_ONE   = 1 << PROGRESS_FRAC_BITS;
  localparam int P_CAP   = (13 * P_ONE) / 10;
  localparam int M1_W    = 8 + P_W;
  localparam int K2_W    = 10;
  localparam int M2_W    = K2_W + PROGRESS_FRAC_BITS;
  localparam int Y_W     = 10;
  localparam int DIV3_W  = 12;
  localparam int DIV3_MUL = 2731;
  localparam int DIV3_SH  = 13;

  localparam logic [1:0] CFG_DUR_A   = 2'd0;
  localparam logic [1:0] CFG_DUR_B   = 2'd1;
  localparam logic [1:0] CFG_PAL_A   = 2'd2;
  localparam logic [1:0] CFG_DEBOUNCE = 2'd3;

  localparam logic [1:0] PAL_SAUSAGE = 2'd0;
  localparam logic [1:0] PAL_TOMATO  = 2'd1;
  localparam logic [1:0] PAL_TEA     = 2'd2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_a_level;
    logic        button_b_level;
  } in_t;

  typedef struct packed {
    logic       active_a;
    logic       palette_a_used;
    logic [7:0] red_a;
    logic [7:0] green_a;
    logic [7:0] blue_a;
    logic       active_b;
    logic [7:0] red_b;
    logic [7:0] green_b;
    logic [7:0] blue_b;
  } out_t;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  // k2x10 holds the second-segment slope already scaled by ten
  typedef struct packed {
    logic [7:0]      base1;
    logic [7:0]      k1;
    logic [7:0]      base2;
    logic [K2_W-1:0] k2x10;
    logic            add2;
  } ramp_t;

  function automatic ramp_t ramp_of(input logic [1:0] pal, input logic [1:0] comp);
    ramp_t r;
    r = '0;
    unique case ({pal, comp})
      {PAL_SAUSAGE, 2'd0}: r = '{8'd255, 8'd95,  8'd160, 10'd950,  1'b1};
      {PAL_SAUSAGE, 2'd1}: r = '{8'd105, 8'd25,  8'd80,  10'd800,  1'b0};
      {PAL_SAUSAGE, 2'd2}: r = '{8'd180, 8'd160, 8'd20,  10'd200,  1'b0};
      {PAL_TOMATO,  2'd0}: r = '{8'd255, 8'd55,  8'd200, 10'd500,  1'b0};
      {PAL_TOMATO,  2'd1}: r = '{8'd120, 8'd80,  8'd40,  10'd250,  1'b0};
      {PAL_TOMATO,  2'd2}: r = '{8'd80,  8'd60,  8'd20,  10'd100,  1'b0};
      {PAL_TEA,     2'd0}: r = '{8'd200, 8'd200, 8'd0,   10'd0,    1'b1};
      {PAL_TEA,     2'd1}: r = '{8'd255, 8'd75,  8'd180, 10'd1000, 1'b0};
      {PAL_TEA,     2'd2}: r = '{8'd200, 8'd200, 8'd0,   10'd0,    1'b1};
      default:             r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/tlcg_div.sv
// Restoring divider, one quotient bit per cycle, for ramp progress.
// Computes min(elapsed * 2^PROGRESS_FRAC_BITS / duration, cap); uses tlcg_pkg.
module tlcg_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tlcg_pkg::TIME_BITS-1:0]  elapsed,
  input  logic [tlcg_pkg::DUR_W-1:0]      divisor,
  output logic                            done,
  output logic [tlcg_pkg::P_W-1:0]        prog
);

  logic                           busy_r, busy_nxt;
  logic [tlcg_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [tlcg_pkg::NUM_W-1:0]     num_r, num_nxt;
  logic [tlcg_pkg::DUR_W-1:0]     rem_r, rem_nxt;
  logic [tlcg_pkg::DUR_W-1:0]     dsr_r, dsr_nxt;
  logic [tlcg_pkg::P_W-1:0]       quo_r, quo_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [tlcg_pkg::DUR_W:0]       trial;
  logic [tlcg_pkg::DUR_W:0]       diff;
  logic                           ge;

  always_comb begin
    trial    = {rem_r, num_r[tlcg_pkg::NUM_W-1]};
    diff     = trial - {1'b0, dsr_r};
    ge       = (trial >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = {elapsed, {tlcg_pkg::PROGRESS_FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      num_nxt = {num_r[tlcg_pkg::NUM_W-2:0], 1'b0};
      rem_nxt = ge ? diff[tlcg_pkg::DUR_W-1:0] : trial[tlcg_pkg::DUR_W-1:0];
      ovf_nxt = ovf_r | quo_r[tlcg_pkg::P_W-1];
      quo_nxt = {quo_r[tlcg_pkg::P_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == tlcg_pkg::CNT_W'(tlcg_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done = !busy_r;
  assign prog = (ovf_r || (quo_r > tlcg_pkg::P_W'(tlcg_pkg::P_CAP))) ?
                tlcg_pkg::P_W'(tlcg_pkg::P_CAP) : quo_r;

endmodule

// File: rtl/core/tlcg_ctrl.sv
// Sequencer of the timed LED color gradient core: accept, divide, multiply, deliver.
// Drives datapath commands from its status; uses tlcg_pkg.
module tlcg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tlcg_pkg::sts_t sts,
  output tlcg_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  always_comb begin
    out_free     = !out_valid_r || out_ready;
    cmd.accept   = (state_r == ST_IDLE) && in_valid;
    cmd.mul_en   = (state_r == ST_DIV) && sts.div_done;
    cmd.load_out = (state_r == ST_FIN) && out_free;
    state_nxt    = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd.accept) state_nxt = ST_DIV;
      ST_DIV:  if (cmd.mul_en) state_nxt = ST_FIN;
      ST_FIN:  if (cmd.load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/tlcg_datapath.sv
// Datapath: configuration, button edge state, two progress dividers, color ramps.
// Depends on tlcg_pkg and tlcg_div; steered by tlcg_ctrl commands.
module tlcg_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_idx,
  input  logic [tlcg_pkg::CFG_W-1:0]  cfg_data,
  input  tlcg_pkg::in_t               in_data,
  input  tlcg_pkg::cmd_t              cmd,
  output tlcg_pkg::sts_t              sts,
  output tlcg_pkg::out_t              out_data
);

  localparam int TB = tlcg_pkg::TIME_BITS;
  localparam int FB = tlcg_pkg::PROGRESS_FRAC_BITS;

  logic [tlcg_pkg::DUR_W-1:0] dur_r [2];
  logic                       pal_r;
  logic [tlcg_pkg::DEB_W-1:0] deb_r;

  logic          prior_r [2];
  logic          run_r   [2];
  logic [TB-1:0] start_r [2];
  logic [TB-1:0] last_r  [2];

  logic          lvl     [2];
  logic          fire    [2];
  logic [TB-1:0] since   [2];
  logic [TB-1:0] elapsed [2];
  logic [TB-1:0] now_t;

  logic                       done   [2];
  logic [tlcg_pkg::P_W-1:0]   prog   [2];

  logic                        hi_r [2][3];
  logic [tlcg_pkg::M1_W-1:0]   m1_r [2][3];
  logic [tlcg_pkg::M2_W-1:0]   m2_r [2][3];
  logic                        hi_nxt [2][3];
  logic [tlcg_pkg::M1_W-1:0]   m1_nxt [2][3];
  logic [tlcg_pkg::M2_W-1:0]   m2_nxt [2][3];
  logic [7:0]                  col    [2][3];

  tlcg_pkg::out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r[0] <= tlcg_pkg::DUR_W'(10000);
      dur_r[1] <= tlcg_pkg::DUR_W'(10000);
      pal_r    <= 1'b0;
      deb_r    <= tlcg_pkg::DEB_W'(200);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tlcg_pkg::CFG_DUR_A:    dur_r[0] <= cfg_data[tlcg_pkg::DUR_W-1:0];
        tlcg_pkg::CFG_DUR_B:    dur_r[1] <= cfg_data[tlcg_pkg::DUR_W-1:0];
        tlcg_pkg::CFG_PAL_A:    pal_r    <= cfg_data[0];
        tlcg_pkg::CFG_DEBOUNCE: deb_r    <= cfg_data[tlcg_pkg::DEB_W-1:0];
        default:                pal_r    <= pal_r;
      endcase
    end
  end

  always_comb begin
    now_t  = in_data.now_ms[TB-1:0];
    lvl[0] = in_data.button_a_level;
    lvl[1] = in_data.button_b_level;
    for (int ch = 0; ch < 2; ch++) begin
      since[ch]   = now_t - last_r[ch];
      fire[ch]    = !lvl[ch] && prior_r[ch] && (since[ch] > TB'(deb_r));
      elapsed[ch] = (fire[ch] && !run_r[ch]) ? '0 : (now_t - start_r[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < 2; ch++) begin
        prior_r[ch] <= 1'b1;
        run_r[ch]   <= 1'b0;
        start_r[ch] <= '0;
        last_r[ch]  <= '0;
      end
    end else if (cmd.accept) begin
      for (int ch = 0; ch < 2; ch++) begin
        prior_r[ch] <= lvl[ch];
        if (fire[ch]) begin
          last_r[ch] <= now_t;
          run_r[ch]  <= !run_r[ch];
          if (!run_r[ch]) begin
            start_r[ch] <= now_t;
          end
        end
      end
    end
  end

  tlcg_div u_div_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.accept),
    .elapsed (elapsed[0]),
    .divisor (dur_r[0]),
    .done    (done[0]),
    .prog    (prog[0])
  );

  tlcg_div u_div_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.accept),
    .elapsed (elapsed[1]),
    .divisor (dur_r[1]),
    .done    (done[1]),
    .prog    (prog[1])
  );

  assign sts.div_done = done[0] && done[1];

  always_comb begin
    tlcg_pkg::ramp_t         r;
    logic [1:0]              pal;
    logic [FB-1:0]           pd;
    logic [tlcg_pkg::Y_W-1:0] y;
    logic [tlcg_pkg::Y_W+tlcg_pkg::DIV3_W-1:0] yq;
    logic [7:0]              d;
    for (int ch = 0; ch < 2; ch++) begin
      pal = (ch == 0) ? {1'b0, pal_r} : tlcg_pkg::PAL_TEA;
      pd  = prog[ch][FB-1:0];
      for (int c = 0; c < 3; c++) begin
        r = tlcg_pkg::ramp_of(pal, 2'(c));
        hi_nxt[ch][c] = prog[ch] > tlcg_pkg::P_W'(tlcg_pkg::P_ONE);
        m1_nxt[ch][c] = tlcg_pkg::M1_W'(r.k1) * tlcg_pkg::M1_W'(prog[ch]);
        m2_nxt[ch][c] = tlcg_pkg::M2_W'(r.k2x10) * tlcg_pkg::M2_W'(pd);

        r  = tlcg_pkg::ramp_of(pal, 2'(c));
        y  = m2_r[ch][c][FB +: tlcg_pkg::Y_W];
        yq = (tlcg_pkg::Y_W + tlcg_pkg::DIV3_W)'(y) *
             (tlcg_pkg::Y_W + tlcg_pkg::DIV3_W)'(tlcg_pkg::DIV3_MUL);
        if (hi_r[ch][c]) begin
          d = yq[tlcg_pkg::DIV3_SH +: 8];
          col[ch][c] = r.add2 ? (r.base2 + d) : (r.base2 - d);
        end else begin
          d = m1_r[ch][c][FB +: 8];
          col[ch][c] = r.base1 - d;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      for (int ch = 0; ch < 2; ch++) begin
        for (int c = 0; c < 3; c++) begin
          hi_r[ch][c] <= hi_nxt[ch][c];
          m1_r[ch][c] <= m1_nxt[ch][c];
          m2_r[ch][c] <= m2_nxt[ch][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.active_a       <= run_r[0];
      out_r.palette_a_used <= pal_r;
      out_r.red_a          <= run_r[0] ? col[0][0] : 8'd0;
      out_r.green_a        <= run_r[0] ? col[0][1] : 8'd0;
      out_r.blue_a         <= run_r[0] ? col[0][2] : 8'd0;
      out_r.active_b       <= run_r[1];
      out_r.red_b          <= run_r[1] ? col[1][0] : 8'd0;
      out_r.green_b        <= run_r[1] ? col[1][1] : 8'd0;
      out_r.blue_b         <= run_r[1] ? col[1][2] : 8'd0;
    end
  end

  assign out_data = out_r;

endmodule

// File: rtl/core/timed_led_color_gradient_core.sv
// Top level of the timed LED color gradient core: two timed color ramps per time sample.
// A beat passes the divider steps, the multiply register load and the output register load
// between the accepting input edge and out_valid.
// A new input beat is accepted only after the previous one is loaded into the output register.
// The output register holds a finished beat while the next input beat runs through the divider.
// Reset (rst_n low, synchronous): buttons released, ramps stopped, registers at defaults.
module timed_led_color_gradient_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_idx,
  input  logic [tlcg_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tlcg_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tlcg_pkg::out_t              out_data
);

  tlcg_pkg::cmd_t cmd;
  tlcg_pkg::sts_t sts;

  tlcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlcg_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: verif/tb_timed_led_color_gradient_core.sv
// Self-checking testbench of timed_led_color_gradient_core.
// Runs a directed table, then randomized sample streams; every result beat is checked against
// its table value or an in-bench ramp predictor. Depends on tlcg_pkg and the core RTL only.
module tb_timed_led_color_gradient_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE_Q10 = 1024;
  localparam int CAP_Q10 = 1331;
  localparam int SETTLE_CYCLES = 64;
  localparam int RAND_PHASES = 12;
  localparam int BEATS_PER_PHASE = 130;

  // [palette][component]: first-segment base and slope, second-segment base, slope, direction
  localparam int SHADE_B1 [3][3] = '{'{255, 105, 180}, '{255, 120, 80}, '{200, 255, 200}};
  localparam int SHADE_K1 [3][3] = '{'{95, 25, 160}, '{55, 80, 60}, '{200, 75, 200}};
  localparam int SHADE_B2 [3][3] = '{'{160, 80, 20}, '{200, 40, 20}, '{0, 180, 0}};
  localparam int SHADE_K2 [3][3] = '{'{95, 80, 20}, '{50, 25, 10}, '{0, 100, 0}};
  localparam bit SHADE_UP [3][3] = '{'{1, 0, 0}, '{0, 0, 0}, '{1, 0, 1}};

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    logic [1:0]     idx;
    logic [31:0]    data;
    tlcg_pkg::in_t  beat;
    bit             typed;
    tlcg_pkg::out_t want;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [1:0]                 cfg_idx;
  logic [tlcg_pkg::CFG_W-1:0] cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  tlcg_pkg::in_t              in_data;
  logic                       out_valid;
  logic                       out_ready;
  tlcg_pkg::out_t             out_data;

  timed_led_color_gradient_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // predictor copy of the registers and per-channel state
  logic [31:0] dur_a_cfg;
  logic [31:0] dur_b_cfg;
  logic        pal_a_cfg;
  logic [15:0] debounce_cfg;
  logic        prior_lvl [2];
  logic        running_ch [2];
  logic [31:0] start_ms [2];
  logic [31:0] last_edge_ms [2];

  tlcg_pkg::out_t color_q [$];
  tlcg_pkg::out_t head;
  dir_row_t       dir_tab [$];
  int             mismatches = 0;
  int             sent_beats = 0;
  int             ramp_starts = 0;
  int             reg_writes = 0;
  int             send_idle_pct = 35;
  int             recv_idle_pct = 52;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timed_led_color_gradient_core regression: fail");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic int progress_of_ramp(logic [31:0] elapsed, logic [31:0] dur);
    logic [41:0] q;
    if (dur == '0) return CAP_Q10;
    q = {elapsed, 10'd0} / {10'd0, dur};
    return (q > CAP_Q10) ? CAP_Q10 : int'(q);
  endfunction

  function automatic logic [7:0] shade_of(int pal, int comp, int p);
    int d;
    if (p <= ONE_Q10) begin
      d = (SHADE_K1[pal][comp] * p) / ONE_Q10;
      return 8'(SHADE_B1[pal][comp] - d);
    end
    d = (SHADE_K2[pal][comp] * (p - ONE_Q10) * 10) / (3 * ONE_Q10);
    return SHADE_UP[pal][comp] ? 8'(SHADE_B2[pal][comp] + d) : 8'(SHADE_B2[pal][comp] - d);
  endfunction

  function automatic tlcg_pkg::out_t advance_ramps(tlcg_pkg::in_t beat);
    tlcg_pkg::out_t o;
    logic           lvl;
    logic [31:0]    since;
    int             p;
    int             pal;
    for (int ch = 0; ch < 2; ch++) begin
      lvl = (ch == 0) ? beat.button_a_level : beat.button_b_level;
      since = beat.now_ms - last_edge_ms[ch];
      if (!lvl && prior_lvl[ch] && since > {16'd0, debounce_cfg}) begin
        last_edge_ms[ch] = beat.now_ms;
        running_ch[ch] = ~running_ch[ch];
        if (running_ch[ch]) begin
          start_ms[ch] = beat.now_ms;
          ramp_starts++;
        end
      end
      prior_lvl[ch] = lvl;
    end
    o = '0;
    o.active_a = running_ch[0];
    o.palette_a_used = pal_a_cfg;
    if (running_ch[0]) begin
      pal = pal_a_cfg ? int'(tlcg_pkg::PAL_TOMATO) : int'(tlcg_pkg::PAL_SAUSAGE);
      p = progress_of_ramp(beat.now_ms - start_ms[0], dur_a_cfg);
      o.red_a = shade_of(pal, 0, p);
      o.green_a = shade_of(pal, 1, p);
      o.blue_a = shade_of(pal, 2, p);
    end
    o.active_b = running_ch[1];
    if (running_ch[1]) begin
      p = progress_of_ramp(beat.now_ms - start_ms[1], dur_b_cfg);
      o.red_b = shade_of(int'(tlcg_pkg::PAL_TEA), 0, p);
      o.green_b = shade_of(int'(tlcg_pkg::PAL_TEA), 1, p);
      o.blue_b = shade_of(int'(tlcg_pkg::PAL_TEA), 2, p);
    end
    return o;
  endfunction

  function automatic dir_row_t beat_row(logic [31:0] now, logic a, logic b);
    dir_row_t r;
    r.kind = ROW_BEAT;
    r.idx = tlcg_pkg::CFG_DUR_A;
    r.data = '0;
    r.beat = '{now_ms: now, button_a_level: a, button_b_level: b};
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic dir_row_t known_row(logic [31:0] now, logic a, logic b,
                                         tlcg_pkg::out_t want);
    dir_row_t r;
    r = beat_row(now, a, b);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [1:0] idx, logic [31:0] data);
    dir_row_t r;
    r = beat_row('0, 1'b1, 1'b1);
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic logic [31:0] pick_duration();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'd1;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel == 2) return $urandom() | 32'd1;
    if (sel < 6) return $urandom_range(1, 64);
    return $urandom_range(65, 4000);
  endfunction

  function automatic logic [15:0] pick_debounce();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 16'd0;
    if (sel == 1) return 16'hFFFF;
    if (sel == 2) return 16'($urandom());
    return 16'($urandom_range(1, 300));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tlcg_pkg::CFG_DUR_A:    dur_a_cfg = data;
      tlcg_pkg::CFG_DUR_B:    dur_b_cfg = data;
      tlcg_pkg::CFG_PAL_A:    pal_a_cfg = data[0];
      tlcg_pkg::CFG_DEBOUNCE: debounce_cfg = data[15:0];
      default:                ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // drop valid, drain every pending result, then let the pipe go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_beat(input tlcg_pkg::in_t beat, input bit typed,
                           input tlcg_pkg::out_t want);
    int             gap;
    tlcg_pkg::out_t guess;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    guess = advance_ramps(beat);
    color_q.push_back(typed ? want : guess);
    sent_beats++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (color_q.size() == 0) begin
        $error("result beat with no sample pending");
        mismatches++;
      end else begin
        head = color_q.pop_front();
        check_field("active_a", head.active_a, out_data.active_a);
        check_field("palette_a_used", head.palette_a_used, out_data.palette_a_used);
        check_field("red_a", head.red_a, out_data.red_a);
        check_field("green_a", head.green_a, out_data.green_a);
        check_field("blue_a", head.blue_a, out_data.blue_a);
        check_field("active_b", head.active_b, out_data.active_b);
        check_field("red_b", head.red_b, out_data.red_b);
        check_field("green_b", head.green_b, out_data.green_b);
        check_field("blue_b", head.blue_b, out_data.blue_b);
      end
    end
  end

  initial begin
    tlcg_pkg::in_t beat;
    dir_row_t      row;
    logic          lvl_a;
    logic          lvl_b;
    logic [31:0]   clock_ms;
    int unsigned   span;
    int unsigned   step_cap;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = tlcg_pkg::CFG_DUR_A;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    dur_a_cfg = 32'd10000;
    dur_b_cfg = 32'd10000;
    pal_a_cfg = 1'b0;
    debounce_cfg = 16'd200;
    for (int ch = 0; ch < 2; ch++) begin
      prior_lvl[ch] = 1'b1;
      running_ch[ch] = 1'b0;
      start_ms[ch] = '0;
      last_edge_ms[ch] = '0;
    end

    // defaults: debounce boundary, fresh start, mid, full, cap, time wrap, stop
    dir_tab.push_back(known_row(32'd0, 1'b1, 1'b1, '0));
    dir_tab.push_back(known_row(32'd200, 1'b0, 1'b0, '0));
    dir_tab.push_back(known_row(32'd300, 1'b1, 1'b1, '0));
    dir_tab.push_back(known_row(32'd500, 1'b0, 1'b0,
        tlcg_pkg::out_t'{1'b1, 1'b0, 8'd255, 8'd105, 8'd180, 1'b1, 8'd200, 8'd255, 8'd200}));
    dir_tab.push_back(beat_row(32'd5500, 1'b1, 1'b1));
    dir_tab.push_back(known_row(32'd10500, 1'b1, 1'b1,
        tlcg_pkg::out_t'{1'b1, 1'b0, 8'd160, 8'd80, 8'd20, 1'b1, 8'd0, 8'd180, 8'd0}));
    dir_tab.push_back(beat_row(32'd13500, 1'b1, 1'b1));
    dir_tab.push_back(beat_row(32'hFFFF_FFFF, 1'b1, 1'b1));
    dir_tab.push_back(beat_row(32'd20000, 1'b0, 1'b1));
    dir_tab.push_back(known_row(32'd20100, 1'b1, 1'b0, '0));
    // tomato palette, also visible while the channel is stopped
    dir_tab.push_back(reg_row(tlcg_pkg::CFG_PAL_A, 32'd1));
    dir_tab.push_back(known_row(32'd20150, 1'b1, 1'b1,
        tlcg_pkg::out_t'{1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0}));
    dir_tab.push_back(known_row(32'd20500, 1'b0, 1'b1,
        tlcg_pkg::out_t'{1'b1, 1'b1, 8'd255, 8'd120, 8'd80, 1'b0, 8'd0, 8'd0, 8'd0}));
    dir_tab.push_back(beat_row(32'd25500, 1'b1, 1'b1));
    dir_tab.push_back(beat_row(32'd33500, 1'b1, 1'b1));
    // zero and maximum duration, no debounce
    dir_tab.push_back(reg_row(tlcg_pkg::CFG_DUR_A, 32'd0));
    dir_tab.push_back(reg_row(tlcg_pkg::CFG_DUR_B, 32'hFFFF_FFFF));
    dir_tab.push_back(reg_row(tlcg_pkg::CFG_DEBOUNCE, 32'd0));
    dir_tab.push_back(beat_row(32'd33501, 1'b1, 1'b1));
    dir_tab.push_back(beat_row(32'd33502, 1'b1, 1'b0));
    dir_tab.push_back(beat_row(32'd33502, 1'b1, 1'b1));
    dir_tab.push_back(beat_row(32'd33501, 1'b1, 1'b1));
    dir_tab.push_back(beat_row(32'd33501, 1'b0, 1'b1));
    dir_tab.push_back(beat_row(32'd33501, 1'b1, 1'b1));
    dir_tab.push_back(beat_row(32'd33501, 1'b0, 1'b1));
    // maximum debounce, unit duration
    dir_tab.push_back(reg_row(tlcg_pkg::CFG_DEBOUNCE, 32'h0000_FFFF));
    dir_tab.push_back(reg_row(tlcg_pkg::CFG_DUR_A, 32'd1));
    dir_tab.push_back(beat_row(32'd33600, 1'b1, 1'b1));
    dir_tab.push_back(beat_row(32'd40000, 1'b0, 1'b1));
    dir_tab.push_back(beat_row(32'd99037, 1'b1, 1'b1));
    dir_tab.push_back(beat_row(32'd99037, 1'b0, 1'b1));
    dir_tab.push_back(beat_row(32'd99038, 1'b1, 1'b1));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_REG) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_beat(row.beat, row.typed, row.want);
      end
    end
    settle();

    clock_ms = $urandom();
    lvl_a = 1'b1;
    lvl_b = 1'b1;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < RAND_PHASES / 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 52;
      end else if (ph < 2 * RAND_PHASES / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 0) begin
        write_reg(tlcg_pkg::CFG_DUR_A, 32'd1);
        write_reg(tlcg_pkg::CFG_DUR_B, 32'hFFFF_FFFF);
        write_reg(tlcg_pkg::CFG_DEBOUNCE, 32'd0);
      end else if (ph == 1) begin
        write_reg(tlcg_pkg::CFG_DUR_A, 32'hFFFF_FFFF);
        write_reg(tlcg_pkg::CFG_DUR_B, 32'd1);
        write_reg(tlcg_pkg::CFG_DEBOUNCE, 32'h0000_FFFF);
      end else begin
        write_reg(tlcg_pkg::CFG_DUR_A, pick_duration());
        write_reg(tlcg_pkg::CFG_DUR_B, pick_duration());
        write_reg(tlcg_pkg::CFG_DEBOUNCE, {16'd0, pick_debounce()});
      end
      write_reg(tlcg_pkg::CFG_PAL_A, 32'($urandom_range(0, 1)));

      span = $urandom_range(0, 1) ? dur_a_cfg : dur_b_cfg;
      step_cap = span / 8 + 1;
      if (step_cap > 32'h0010_0000) step_cap = 32'h0010_0000;
      if (step_cap < debounce_cfg / 3 + 1) step_cap = debounce_cfg / 3 + 1;

      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          beat.now_ms = $urandom();
          beat.button_a_level = 1'($urandom_range(0, 1));
          beat.button_b_level = 1'($urandom_range(0, 1));
        end else begin
          clock_ms = clock_ms + $urandom_range(0, step_cap);
          if ($urandom_range(0, 99) < 20) lvl_a = ~lvl_a;
          if ($urandom_range(0, 99) < 20) lvl_b = ~lvl_b;
          beat.now_ms = clock_ms;
          beat.button_a_level = lvl_a;
          beat.button_b_level = lvl_b;
        end
        send_beat(beat, 1'b0, '0);
      end
      settle();
    end

    $display("covered %0d sample beats, %0d register writes, %0d ramp starts",
             sent_beats, reg_writes, ramp_starts);
    if (mismatches == 0) begin
      $display("timed_led_color_gradient_core regression: pass");
    end else begin
      $display("timed_led_color_gradient_core regression: fail");
    end
    $finish;
  end

endmodule
